// ----- rtl/mnca_pkg.sv -----
// Package for the MIDI note channel allocator.
// Shared constants, controller state and command/status types. No dependencies.
`timescale 1ns / 1ps

package mnca_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [1:0] FULL_LEN      = 2'd3;
   localparam logic [3:0] NOTE_ON_NIB   = 4'h9;
   localparam logic [3:0] NOTE_OFF_NIB  = 4'h8;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EXEC
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // evaluate held item, update slots, fill result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_stall;   // result register full and not taken this cycle
   } ctl_sts_type;

endpackage

// ----- rtl/mnca_ctrl.sv -----
// Sequencer for the MIDI note channel allocator: load an item, then evaluate it.
// Depends on mnca_pkg.
`timescale 1ns / 1ps

module mnca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mnca_pkg::ctl_sts_type sts,
   output mnca_pkg::ctl_cmd_type cmd
);
   import mnca_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!sts.out_stall) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = !sts.out_stall;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/mnca_dpath.sv -----
// Datapath of the MIDI note channel allocator: item register, slot table,
// free/match priority search, result register and channel register. Depends on mnca_pkg.
`timescale 1ns / 1ps

module mnca_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  mnca_pkg::ctl_cmd_type cmd,
   output mnca_pkg::ctl_sts_type sts,
   input  logic [31:0]           req_time_stamp,
   input  logic [1:0]            req_msg_length,
   input  logic [7:0]            req_status_byte,
   input  logic [7:0]            req_data_one,
   input  logic [7:0]            req_data_two,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_out_time,
   output logic [1:0]            rsp_out_length,
   output logic [7:0]            rsp_out_status,
   output logic [7:0]            rsp_out_key,
   output logic [7:0]            rsp_out_velocity
);
   import mnca_pkg::*;

   logic [3:0]  split_channel_ff;
   logic [31:0] time_ff;
   logic [1:0]  len_ff;
   logic [7:0]  st_ff, b1_ff, b2_ff;

   logic [NUM_SLOTS-1:0] slot_used_ff;
   logic [6:0]           slot_key_ff [NUM_SLOTS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       out_time_ff;
   logic [1:0]        out_len_ff;
   logic [7:0]        out_status_ff, out_key_ff, out_vel_ff;
   logic [7:0]        out_status_in, out_key_in, out_vel_in;

   logic              is_pass, is_note, on_req, hit, emit;
   logic [6:0]        key, vel;
   logic              free_hit, match_hit;
   logic [SLOT_W-1:0] free_idx, match_idx, slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_channel_ff <= 4'd0;
      end else if (csr_wr_en) begin
         split_channel_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_time_stamp;
         len_ff  <= req_msg_length;
         st_ff   <= req_status_byte;
         b1_ff   <= req_data_one;
         b2_ff   <= req_data_two;
      end
   end

   // decode
   always_comb begin
      key     = b1_ff[6:0];
      vel     = b2_ff[6:0];
      is_pass = (len_ff != FULL_LEN);
      is_note = (st_ff[3:0] == split_channel_ff)
              && ((st_ff[7:4] == NOTE_ON_NIB) || (st_ff[7:4] == NOTE_OFF_NIB));
      on_req  = (st_ff[7:4] == NOTE_ON_NIB) && (vel != 7'd0);
   end

   // lowest empty slot and lowest slot holding the key; descending so lowest wins
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(i);
         end
         if (slot_used_ff[i] && (slot_key_ff[i] == key)) begin
            match_hit = 1'b1;
            match_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      hit  = on_req ? free_hit : match_hit;
      slot = on_req ? free_idx : match_idx;
      emit = is_pass || (is_note && hit);
      if (is_pass) begin
         out_status_in = (len_ff >= 2'd1) ? st_ff : 8'd0;
         out_key_in    = (len_ff >= 2'd2) ? b1_ff : 8'd0;
         out_vel_in    = 8'd0;
      end else begin
         out_status_in = {(on_req ? NOTE_ON_NIB : NOTE_OFF_NIB), 4'd0} | 8'(slot);
         out_key_in    = {1'b0, key};
         out_vel_in    = {1'b0, vel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
      end else if (cmd.exec && !is_pass && is_note && hit) begin
         slot_used_ff[slot] <= on_req;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && !is_pass && is_note && on_req && free_hit) begin
         slot_key_ff[free_idx] <= key;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && emit) begin
         out_time_ff   <= time_ff;
         out_len_ff    <= len_ff;
         out_status_ff <= out_status_in;
         out_key_ff    <= out_key_in;
         out_vel_ff    <= out_vel_in;
      end
   end

   assign sts.out_stall    = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_time     = out_time_ff;
   assign rsp_out_length   = out_len_ff;
   assign rsp_out_status   = out_status_ff;
   assign rsp_out_key      = out_key_ff;
   assign rsp_out_velocity = out_vel_ff;

endmodule

// ----- rtl/midi_note_channel_allocator.sv -----
// Flow: an item is loaded into the item register at the accepting edge, then
// evaluated into the result register by the load/evaluate sequencer, which
// takes no new item until the held one is evaluated. The result register lets
// the next item be taken while a result waits, and evaluation holds for as
// long as a result waits with rsp_ready low.
// Reset: synchronous, active high; all 16 slots empty, split channel 0,
// no result pending.
`timescale 1ns / 1ps

module midi_note_channel_allocator (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_time_stamp,
   input  logic [1:0]  req_msg_length,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_data_one,
   input  logic [7:0]  req_data_two,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_time,
   output logic [1:0]  rsp_out_length,
   output logic [7:0]  rsp_out_status,
   output logic [7:0]  rsp_out_key,
   output logic [7:0]  rsp_out_velocity,
   // split channel register
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import mnca_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // Controller: waits for an item, then holds in evaluate until the
   // result register can take the outcome.
   mnca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: messages not three bytes long pass through. On the split channel,
   // note-on takes the lowest free slot, note-off or velocity-0 note-on frees the
   // lowest slot with its key; the slot number is the new channel. Rest dropped.
   mnca_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_time_stamp   (req_time_stamp),
      .req_msg_length   (req_msg_length),
      .req_status_byte  (req_status_byte),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_time     (rsp_out_time),
      .rsp_out_length   (rsp_out_length),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_velocity (rsp_out_velocity)
   );

endmodule

// ----- tb/midi_note_channel_allocator_tb.sv -----
// Testbench for the MIDI note channel allocator: random and directed MIDI messages
// are checked against a slot-tracking predictor. Depends on rtl/mnca_pkg.sv and
// rtl/midi_note_channel_allocator.sv.
`timescale 1ns / 1ps

module midi_note_channel_allocator_tb;
   import mnca_pkg::*;

   localparam int SETTLE_CYCLES = 4;          // margin on top of the block's result delay
   localparam int RUN_LIMIT_NS  = 2_000_000;

   // one MIDI message, used for both the request and the routed result
   typedef struct packed {
      logic [31:0] stamp;
      logic [1:0]  len;
      logic [7:0]  status;
      logic [7:0]  key;
      logic [7:0]  vel;
   } midi_msg_type;

   typedef enum logic [1:0] {
      PEND_MSG,     // send a message
      PEND_SPLIT,   // quiesce, then retune the split channel
      PEND_DRAIN    // quiesce only
   } pend_kind_type;

   typedef struct packed {
      pend_kind_type kind;
      midi_msg_type  msg;
      logic [3:0]    chan;
   } pend_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_time_stamp = '0;
   logic [1:0]  req_msg_length = '0;
   logic [7:0]  req_status_byte = '0;
   logic [7:0]  req_data_one = '0;
   logic [7:0]  req_data_two = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_time;
   logic [1:0]  rsp_out_length;
   logic [7:0]  rsp_out_status;
   logic [7:0]  rsp_out_key;
   logic [7:0]  rsp_out_velocity;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   // predictor state: split channel and per-slot held key
   logic [3:0]  split_ch;
   logic        slot_held [NUM_SLOTS];
   logic [6:0]  held_key  [NUM_SLOTS];

   pend_type     msg_backlog[$];   // stimulus not yet driven
   midi_msg_type routed_q[$];      // messages the block still owes us
   int           fail_count = 0;

   midi_note_channel_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_stamp   (req_time_stamp),
      .req_msg_length   (req_msg_length),
      .req_status_byte  (req_status_byte),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_time     (rsp_out_time),
      .rsp_out_length   (rsp_out_length),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_velocity (rsp_out_velocity),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: routes one message, updating the slot table. Returns 1 when the
   // block must emit a message.
   // ---------------------------------------------------------------------------
   function automatic bit route_note(input midi_msg_type m, output midi_msg_type r);
      logic [3:0] kind;
      logic [6:0] key;
      logic [6:0] vel;
      int         slot;
      r = '0;
      // anything but a three-byte message passes through, bytes past the length zeroed
      if (m.len != FULL_LEN) begin
         r.stamp  = m.stamp;
         r.len    = m.len;
         r.status = (m.len >= 2'd1) ? m.status : 8'h00;
         r.key    = (m.len >= 2'd2) ? m.key : 8'h00;
         return 1'b1;
      end
      kind = m.status[7:4];
      if (m.status[3:0] != split_ch || (kind != NOTE_ON_NIB && kind != NOTE_OFF_NIB))
         return 1'b0;
      key = m.key[6:0];
      vel = m.vel[6:0];
      if (vel == 7'd0)
         kind = NOTE_OFF_NIB;   // note-on at zero velocity releases
      slot = -1;
      if (kind == NOTE_ON_NIB) begin
         for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
            if (!slot_held[i])
               slot = i;
         if (slot >= 0) begin
            slot_held[slot] = 1'b1;
            held_key[slot]  = key;
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
            if (slot_held[i] && held_key[i] == key)
               slot = i;
         if (slot >= 0) begin
            slot_held[slot] = 1'b0;
            held_key[slot]  = 7'd0;
         end
      end
      if (slot < 0)
         return 1'b0;   // all slots busy, or key not held
      r.stamp  = m.stamp;
      r.len    = FULL_LEN;
      r.status = {kind, 4'(slot)};
      r.key    = {1'b0, key};
      r.vel    = {1'b0, vel};
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: presents backlog messages with random gaps; split-channel writes
   // and drain points wait until the block has gone quiet.
   // ---------------------------------------------------------------------------
   midi_msg_type drv_msg;
   int           gap_left;
   int           quiet;
   bit           send_calm;   // when set, no gaps between items

   always @(posedge clock) begin
      bit           keep;
      bit           present;
      bit           go_wr;
      bit           has_out;
      midi_msg_type out_msg;
      pend_type     head;
      keep    = 1'b0;
      present = 1'b0;
      go_wr   = 1'b0;
      if (reset) begin
         split_ch = 4'd0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_held[i] = 1'b0;
            held_key[i]  = 7'd0;
         end
         gap_left  = $urandom_range(0, 3);
         quiet     = 0;
         send_calm = 1'b0;
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         keep = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            has_out = route_note(drv_msg, out_msg);
            if (has_out)
               routed_q.push_back(out_msg);
            if ($urandom_range(0, 49) == 0)
               send_calm = !send_calm;
            gap_left = send_calm ? 0 : $urandom_range(0, 3);
         end
         // quiet: nothing on the request side and nothing owed
         if (!req_valid && routed_q.size() == 0)
            quiet++;
         else
            quiet = 0;
         if (!keep && msg_backlog.size() != 0) begin
            head = msg_backlog[0];
            if (head.kind != PEND_MSG) begin
               if (quiet >= SETTLE_CYCLES) begin
                  if (head.kind == PEND_SPLIT) begin
                     go_wr = 1'b1;
                     csr_wr_data <= head.chan;
                     split_ch = head.chan;
                  end
                  void'(msg_backlog.pop_front());
                  quiet = 0;
               end
            end else if (gap_left == 0) begin
               present = 1'b1;
               drv_msg = head.msg;
               void'(msg_backlog.pop_front());
               req_time_stamp  <= drv_msg.stamp;
               req_msg_length  <= drv_msg.len;
               req_status_byte <= drv_msg.status;
               req_data_one    <= drv_msg.key;
               req_data_two    <= drv_msg.vel;
            end else begin
               gap_left--;
            end
         end
         req_valid <= keep || present;
         csr_wr_en <= go_wr;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random back-pressure, each result checked against the oldest
   // expectation.
   // ---------------------------------------------------------------------------
   int stall_left;
   bit take_calm;

   always @(posedge clock) begin
      midi_msg_type want;
      if (reset) begin
         stall_left = $urandom_range(0, 3);
         take_calm  = 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (routed_q.size() == 0) begin
               $error("unexpected result: out_time %0h out_status %0h",
                      rsp_out_time, rsp_out_status);
               fail_count++;
            end else begin
               want = routed_q.pop_front();
               if (rsp_out_time !== want.stamp) begin
                  $error("out_time: expected %0h, got %0h", want.stamp, rsp_out_time);
                  fail_count++;
               end
               if (rsp_out_length !== want.len) begin
                  $error("out_length: expected %0d, got %0d", want.len, rsp_out_length);
                  fail_count++;
               end
               if (rsp_out_status !== want.status) begin
                  $error("out_status: expected %0h, got %0h", want.status, rsp_out_status);
                  fail_count++;
               end
               if (rsp_out_key !== want.key) begin
                  $error("out_key: expected %0h, got %0h", want.key, rsp_out_key);
                  fail_count++;
               end
               if (rsp_out_velocity !== want.vel) begin
                  $error("out_velocity: expected %0h, got %0h", want.vel, rsp_out_velocity);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 49) == 0)
               take_calm = !take_calm;
            stall_left = take_calm ? 0 : $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------
   task automatic push_msg(input logic [31:0] stamp, input logic [1:0] len,
                           input logic [7:0] status, input logic [7:0] key,
                           input logic [7:0] vel);
      pend_type p;
      p.kind = PEND_MSG;
      p.msg  = '{stamp: stamp, len: len, status: status, key: key, vel: vel};
      p.chan = '0;
      msg_backlog.push_back(p);
   endtask

   task automatic push_sync(input pend_kind_type kind, input logic [3:0] chan);
      pend_type p;
      p.kind = kind;
      p.msg  = '0;
      p.chan = chan;
      msg_backlog.push_back(p);
   endtask

   // mostly well-formed notes on the split channel from a small key pool, so
   // slots fill up, keys repeat and note-offs find their slot; the rest is noise
   task automatic push_phase(input int count, input int on_pct, input logic [3:0] chan);
      int         pick;
      logic [7:0] key;
      logic [7:0] vel;
      logic [3:0] other;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         key  = 8'($urandom_range(0, 23)) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
         vel  = 8'($urandom);
         if (n == count / 2)
            push_sync(PEND_DRAIN, '0);   // let everything drain once per phase
         if (pick < 8) begin
            push_msg($urandom, 2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                     8'($urandom));
         end else if (pick < 14) begin
            other = 4'($urandom_range(1, 15)) + chan;
            push_msg($urandom, FULL_LEN,
                     {($urandom_range(0, 1) ? NOTE_ON_NIB : NOTE_OFF_NIB), other}, key, vel);
         end else if (pick < 19) begin
            push_msg($urandom, FULL_LEN, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if ($urandom_range(0, 99) < on_pct) begin
            if ($urandom_range(0, 9) == 0)
               vel[6:0] = 7'd0;   // zero-velocity release
            else if (vel[6:0] == 7'd0)
               vel[0] = 1'b1;
            push_msg($urandom, FULL_LEN, {NOTE_ON_NIB, chan}, key, vel);
         end else begin
            push_msg($urandom, FULL_LEN, {NOTE_OFF_NIB, chan}, key, vel);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [3:0] chans [5];
      // pass-through lengths at the extremes (split channel is 0 after reset)
      push_msg(32'hffff_ffff, 2'd0, 8'hff, 8'hff, 8'hff);
      push_msg(32'h0000_0000, 2'd1, 8'hff, 8'hff, 8'hff);
      push_msg(32'hffff_ffff, 2'd2, 8'h90, 8'hff, 8'hff);
      // note-on at key 0 / full velocity, masked key and velocity, note-off
      push_msg(32'h0000_0001, FULL_LEN, {NOTE_ON_NIB, 4'd0}, 8'h00, 8'h7f);
      push_msg(32'h8000_0000, FULL_LEN, {NOTE_ON_NIB, 4'd0}, 8'hff, 8'h81);
      push_msg(32'h0000_0002, FULL_LEN, {NOTE_OFF_NIB, 4'd0}, 8'h00, 8'hff);
      // fill every free slot, then one more note-on that finds none
      for (int k = 0; k < NUM_SLOTS - 1; k++)
         push_msg($urandom, FULL_LEN, {NOTE_ON_NIB, 4'd0}, 8'(10 + k), 8'h40);
      push_msg($urandom, FULL_LEN, {NOTE_ON_NIB, 4'd0}, 8'd60, 8'h40);
      // zero-velocity note-on releases key 127, unknown key, other channel, other type
      push_msg($urandom, FULL_LEN, {NOTE_ON_NIB, 4'd0}, 8'h7f, 8'h80);
      push_msg($urandom, FULL_LEN, {NOTE_OFF_NIB, 4'd0}, 8'd99, 8'h10);
      push_msg($urandom, FULL_LEN, {NOTE_ON_NIB, 4'd5}, 8'd11, 8'h10);
      push_msg($urandom, FULL_LEN, 8'hb0, 8'd11, 8'h10);
      // random phases over several split channels, extremes included
      chans[0] = 4'd15;
      chans[1] = 4'($urandom_range(1, 14));
      chans[2] = 4'd0;
      chans[3] = 4'($urandom_range(1, 14));
      chans[4] = 4'($urandom_range(0, 15));
      for (int ph = 0; ph < 5; ph++) begin
         push_sync(PEND_SPLIT, chans[ph]);
         push_phase(120, (ph % 2 == 0) ? 70 : 35, chans[ph]);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (msg_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (routed_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // run limit: far beyond the slowest legal run
   initial begin
      #(RUN_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
